// ===== rtl/core/nps_pkg.sv =====
// nps_pkg: shared types and constants for the nearest point search block.
// Word formats of both channels, controller/datapath command and status groups.
// No dependencies.
package nps_pkg;

  localparam int NPS_MAX_POINTS = 1024;

  localparam int COORD_W    = 16;
  localparam int IDX_W      = 10;
  localparam int COUNT_W    = 11;
  localparam int DIST_W     = 34;
  localparam int ABS_W      = 16;
  localparam int SQ_W       = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 34;

  localparam logic [DIST_W-1:0] MAX_DIST_RESET = 34'd256000000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST_SQ = 1'd1;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [IDX_W-1:0]          entry_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]          nearest_index;
    logic signed [COORD_W-1:0] nearest_x;
    logic signed [COORD_W-1:0] nearest_y;
    logic signed [COORD_W-1:0] nearest_z;
    logic                      in_range;
    logic                      table_empty;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load_wr;    // write input point into table
    logic q_start;    // latch query position, reset running minimum
    logic issue;      // read one table entry into the pipe
    logic out_load;   // capture result into output register
    logic out_empty;  // result is the empty-table word
  } nps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pipe_busy;  // some entry still in flight toward the compare
  } nps_status_t;

endpackage

// ===== rtl/core/nps_ctrl.sv =====
// nps_ctrl: sequencer for the nearest point search block.
// Handshakes, scan counter, result valid. Depends on nps_pkg.
module nps_ctrl #(
  parameter int MAX_POINTS = nps_pkg::NPS_MAX_POINTS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic [nps_pkg::COUNT_W-1:0]     point_count,
  output logic                            out_valid,
  input  logic                            out_stall,
  output nps_pkg::nps_cmd_t               cmd,
  output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rd_addr,
  input  nps_pkg::nps_status_t            status
);
  import nps_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          empty_r, empty_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] n_sat;
  logic          in_acc;

  // scan length, saturated at table depth
  always_comb begin
    if (32'(point_count) > 32'(MAX_POINTS)) begin
      n_sat = CW'(MAX_POINTS);
    end else begin
      n_sat = CW'(point_count);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign rd_addr   = cnt_r[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.q_start = 1'b1;
            n_nxt       = n_sat;
            cnt_nxt     = '0;
            empty_nxt   = (n_sat == '0);
            state_nxt   = (n_sat == '0) ? ST_FINISH : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (cnt_r == n_r - CW'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the output register to be free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load   = 1'b1;
          cmd.out_empty  = empty_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/nps_datapath.sv =====
// nps_datapath: point table, distance pipeline, running minimum, result register.
// Driven by nps_ctrl commands. Depends on nps_pkg.
module nps_datapath #(
  parameter int MAX_POINTS = nps_pkg::NPS_MAX_POINTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nps_pkg::in_word_t             in_word,
  input  logic [nps_pkg::DIST_W-1:0]    max_dist_sq,
  input  nps_pkg::nps_cmd_t             cmd,
  input  logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rd_addr,
  output nps_pkg::nps_status_t          status,
  output nps_pkg::out_word_t            out_word
);
  import nps_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PW = 3 * COORD_W;

  logic [PW-1:0] mem [MAX_POINTS];

  // query position
  logic signed [COORD_W-1:0] qx_r, qy_r, qz_r;

  // stage 1: table read
  logic          s1_valid_r;
  logic [AW-1:0] s1_idx_r;
  logic [PW-1:0] s1_pt_r;

  // stage 2: absolute differences
  logic          s2_valid_r;
  logic [AW-1:0] s2_idx_r;
  logic [PW-1:0] s2_pt_r;
  logic [ABS_W-1:0] s2_ax_r, s2_ay_r, s2_az_r;

  // stage 3: squares
  logic          s3_valid_r;
  logic [AW-1:0] s3_idx_r;
  logic [PW-1:0] s3_pt_r;
  logic [SQ_W-1:0] s3_sx_r, s3_sy_r, s3_sz_r;

  // stage 4: distance
  logic          s4_valid_r;
  logic [AW-1:0] s4_idx_r;
  logic [PW-1:0] s4_pt_r;
  logic [DIST_W-1:0] s4_dist_r;

  // running minimum
  logic [DIST_W-1:0] best_r;
  logic [AW-1:0]     win_idx_r;
  logic [PW-1:0]     win_pt_r;
  logic              hit_r;

  out_word_t out_r;

  logic          wr_ok;
  logic [AW-1:0] wr_addr;
  logic signed [COORD_W:0] dx, dy, dz;
  logic [ABS_W-1:0] ax, ay, az;
  logic          closer;

  assign wr_ok   = 32'(in_word.entry_index) < 32'(MAX_POINTS);
  assign wr_addr = AW'(in_word.entry_index);

  always_ff @(posedge clk) begin
    if (cmd.load_wr && wr_ok) begin
      mem[wr_addr] <= {in_word.coord_x, in_word.coord_y, in_word.coord_z};
    end
    if (cmd.issue) begin
      s1_pt_r <= mem[rd_addr];
    end
  end

  always_comb begin
    dx = {s1_pt_r[3*COORD_W-1], s1_pt_r[3*COORD_W-1 -: COORD_W]} - {qx_r[COORD_W-1], qx_r};
    dy = {s1_pt_r[2*COORD_W-1], s1_pt_r[2*COORD_W-1 -: COORD_W]} - {qy_r[COORD_W-1], qy_r};
    dz = {s1_pt_r[COORD_W-1],   s1_pt_r[COORD_W-1 -: COORD_W]}   - {qz_r[COORD_W-1], qz_r};
    ax = dx[COORD_W] ? ABS_W'(-dx) : ABS_W'(dx);
    ay = dy[COORD_W] ? ABS_W'(-dy) : ABS_W'(dy);
    az = dz[COORD_W] ? ABS_W'(-dz) : ABS_W'(dz);
  end

  assign closer = s4_dist_r < best_r;

  // pipe control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.issue;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  // pipe payload
  always_ff @(posedge clk) begin
    s1_idx_r  <= rd_addr;

    s2_idx_r  <= s1_idx_r;
    s2_pt_r   <= s1_pt_r;
    s2_ax_r   <= ax;
    s2_ay_r   <= ay;
    s2_az_r   <= az;

    s3_idx_r  <= s2_idx_r;
    s3_pt_r   <= s2_pt_r;
    s3_sx_r   <= s2_ax_r * s2_ax_r;
    s3_sy_r   <= s2_ay_r * s2_ay_r;
    s3_sz_r   <= s2_az_r * s2_az_r;

    s4_idx_r  <= s3_idx_r;
    s4_pt_r   <= s3_pt_r;
    s4_dist_r <= DIST_W'(s3_sx_r) + DIST_W'(s3_sy_r) + DIST_W'(s3_sz_r);
  end

  // query setup and running minimum; entry 0 is the fallback winner
  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      qx_r   <= in_word.coord_x;
      qy_r   <= in_word.coord_y;
      qz_r   <= in_word.coord_z;
      best_r <= max_dist_sq;
      hit_r  <= 1'b0;
    end else if (s4_valid_r) begin
      if (s4_idx_r == '0) begin
        win_idx_r <= s4_idx_r;
        win_pt_r  <= s4_pt_r;
      end else if (closer) begin
        win_idx_r <= s4_idx_r;
        win_pt_r  <= s4_pt_r;
      end
      if (closer) begin
        best_r <= s4_dist_r;
        hit_r  <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_empty) begin
        out_r.nearest_index <= '0;
        out_r.nearest_x     <= '0;
        out_r.nearest_y     <= '0;
        out_r.nearest_z     <= '0;
        out_r.in_range      <= 1'b0;
        out_r.table_empty   <= 1'b1;
      end else begin
        out_r.nearest_index <= IDX_W'(win_idx_r);
        out_r.nearest_x     <= win_pt_r[3*COORD_W-1 -: COORD_W];
        out_r.nearest_y     <= win_pt_r[2*COORD_W-1 -: COORD_W];
        out_r.nearest_z     <= win_pt_r[COORD_W-1 -: COORD_W];
        out_r.in_range      <= hit_r;
        out_r.table_empty   <= 1'b0;
      end
    end
  end

  assign status.pipe_busy = s1_valid_r | s2_valid_r | s3_valid_r | s4_valid_r;
  assign out_word         = out_r;

endmodule

// ===== rtl/core/nearest_point_search.sv =====
// nearest_point_search: top level of the nearest point search block.
// Holds the configuration registers; instantiates nps_ctrl and nps_datapath.
// Depends on nps_pkg.
//
// Input channel (in_valid / in_stall / in_word) carries two kinds of word. A load
// word (req_type = 0) writes one Q11.4 point at entry_index. A query word
// (req_type = 1) scans entries 0 .. point_count-1 (capped at MAX_POINTS) and
// returns one word on out_valid / out_stall / out_word: nearest entry by squared
// distance, strictly below max_distance_sq, first one wins on ties. No hit gives
// entry 0 with in_range clear; a zero count gives table_empty set.
// Timing: loads are accepted back to back while idle. A query holds in_stall high
// from acceptance until its result is loaded into the output register; the
// read port feeds one entry per cycle into a four-stage distance/compare pipe.
// A zero-count query skips the scan and goes straight to loading its result.
// Reset: synchronous, active low; clears control, point_count to 0 and
//   max_distance_sq to 256000000. Table contents are not cleared.
// Stall: the result waits in the output register; loads and a new query are
//   still taken, a finished query holds until the register frees.
// Config: cfg_wr_en writes cfg_wdata to register cfg_index; write only when idle.
module nearest_point_search #(
  parameter int MAX_POINTS = nps_pkg::NPS_MAX_POINTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  nps_pkg::in_word_t                in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output nps_pkg::out_word_t               out_word,
  input  logic                             cfg_wr_en,
  input  logic [nps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import nps_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  logic [COUNT_W-1:0] point_count_r;
  logic [DIST_W-1:0]  max_dist_sq_r;

  nps_cmd_t    cmd;
  nps_status_t status;
  logic [AW-1:0] rd_addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
      max_dist_sq_r <= MAX_DIST_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_POINT_COUNT: point_count_r <= cfg_wdata[COUNT_W-1:0];
        REG_MAX_DIST_SQ: max_dist_sq_r <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  nps_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_word.req_type),
    .point_count (point_count_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .status      (status)
  );

  nps_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_word),
    .max_dist_sq (max_dist_sq_r),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .status      (status),
    .out_word    (out_word)
  );

endmodule

// ===== tb/sv/nps_tb_pkg.sv =====
// nps_tb_pkg: the expected-result store and the nearest point predictor for the
// nearest point search testbench. Depends on nps_pkg for word types and widths.
`timescale 1ns / 100ps

package nps_tb_pkg;
  import nps_pkg::*;

  class nearest_point_scoreboard;
    logic signed [COORD_W-1:0] pt_x [NPS_MAX_POINTS];
    logic signed [COORD_W-1:0] pt_y [NPS_MAX_POINTS];
    logic signed [COORD_W-1:0] pt_z [NPS_MAX_POINTS];
    logic [COUNT_W-1:0]        scan_count;
    logic [DIST_W-1:0]         dist_limit;
    out_word_t                 pending_nearest [$];
    int                        errors;

    function new();
      scan_count = '0;
      dist_limit = MAX_DIST_RESET;
      errors     = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx,
                          input logic [CFG_DATA_W-1:0] val);
      if (idx == REG_POINT_COUNT) scan_count = val[COUNT_W-1:0];
      else if (idx == REG_MAX_DIST_SQ) dist_limit = val[DIST_W-1:0];
    endfunction

    // brute-force scan, running minimum starts at the threshold, strict compare
    function out_word_t nearest_of(input in_word_t q);
      out_word_t r;
      longint    best, d, dx, dy, dz;
      int        n, win;
      bit        hit;
      r = '0;
      n = (scan_count > NPS_MAX_POINTS) ? NPS_MAX_POINTS : int'(scan_count);
      if (n == 0) begin
        r.table_empty = 1'b1;
        return r;
      end
      best = longint'(dist_limit);
      win  = 0;
      hit  = 1'b0;
      for (int i = 0; i < n; i++) begin
        dx = longint'(pt_x[i]) - longint'($signed(q.coord_x));
        dy = longint'(pt_y[i]) - longint'($signed(q.coord_y));
        dz = longint'(pt_z[i]) - longint'($signed(q.coord_z));
        d  = dx * dx + dy * dy + dz * dz;
        if (d < best) begin
          best = d;
          win  = i;
          hit  = 1'b1;
        end
      end
      r.nearest_index = IDX_W'(win);
      r.nearest_x     = pt_x[win];
      r.nearest_y     = pt_y[win];
      r.nearest_z     = pt_z[win];
      r.in_range      = hit;
      return r;
    endfunction

    function void flag(input string what);
      errors++;
      if (errors <= 10) $display("ERROR: %s", what);
    endfunction

    function void note_word(input in_word_t w);
      if (w.req_type == REQ_LOAD) begin
        pt_x[w.entry_index] = w.coord_x;
        pt_y[w.entry_index] = w.coord_y;
        pt_z[w.entry_index] = w.coord_z;
      end else begin
        pending_nearest = {pending_nearest, nearest_of(w)};
      end
    endfunction

    function void check_word(input out_word_t got);
      out_word_t exp;
      if (pending_nearest.size() == 0) begin
        flag("result word with no query pending");
        return;
      end
      exp = pending_nearest.pop_front();
      if (got.nearest_index !== exp.nearest_index || got.nearest_x !== exp.nearest_x ||
          got.nearest_y !== exp.nearest_y || got.nearest_z !== exp.nearest_z ||
          got.in_range !== exp.in_range || got.table_empty !== exp.table_empty)
        flag($sformatf({"mismatch: exp idx=%0d x=%0d y=%0d z=%0d hit=%0b empty=%0b",
                        " | got idx=%0d x=%0d y=%0d z=%0d hit=%0b empty=%0b"},
                       exp.nearest_index, exp.nearest_x, exp.nearest_y, exp.nearest_z,
                       exp.in_range, exp.table_empty,
                       got.nearest_index, got.nearest_x, got.nearest_y, got.nearest_z,
                       got.in_range, got.table_empty));
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_nearest_point_search.sv =====
// tb_nearest_point_search: drives load and query words into nearest_point_search,
// predicts each query result and checks it. Depends on nps_pkg and nps_tb_pkg.
`timescale 1ns / 100ps

module tb_nearest_point_search;
  import nps_pkg::*;
  import nps_tb_pkg::*;

  localparam int HOLD_CYCLES   = 300;    // long receiver hold-off for back-pressure
  localparam int SETTLE_CYCLES = 16;     // quiet time before a register write
  localparam int END_CYCLES    = 20;     // trailing cycles after the last result
  localparam int STUCK_LIMIT   = 20000;  // cycles with no handshake before giving up

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // idle percentages per side, set by the phase in progress
  int gap_pct   = 0;
  int stall_pct = 0;
  bit hold_req  = 1'b0;

  // which slots hold a point; queries never scan beyond the loaded prefix
  bit slot_loaded [NPS_MAX_POINTS];
  int loaded_prefix = 0;

  nearest_point_scoreboard sb = new();

  nearest_point_search u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: both channels sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_word);
      if (out_valid && !out_stall) sb.check_word(out_word);
    end
  end

  // Receiver: random stall per cycle, or one long hold-off on request so the
  // output register and the finished query behind it back up into in_stall.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Watchdog: only cycles without any handshake count toward the limit.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic in_word_t make_word(input logic req, input logic [IDX_W-1:0] idx,
                                         input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y,
                                         input logic signed [COORD_W-1:0] z);
    in_word_t w;
    w.req_type    = req;
    w.entry_index = idx;
    w.coord_x     = x;
    w.coord_y     = y;
    w.coord_z     = z;
    return w;
  endfunction

  // Mostly a cluster near the origin so thresholds bite; some full-range and extremes.
  function automatic logic signed [COORD_W-1:0] rand_coord();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return COORD_W'($urandom);
    if (sel < 40) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh8000;
        1:       return 16'sh7FFF;
        2:       return 16'shFFFF;
        default: return 16'sd0;
      endcase
    end
    return COORD_W'($urandom_range(0, 4000) - 2000);
  endfunction

  // Move a coordinate by up to +/- span, clamped to the Q11.4 range.
  function automatic logic signed [COORD_W-1:0] nudge(input logic signed [COORD_W-1:0] v,
                                                      input int span);
    int t;
    t = int'(v) + int'($urandom_range(0, 2 * span)) - span;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    return COORD_W'(t);
  endfunction

  function automatic logic [DIST_W-1:0] random_limit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DIST_W'(1);
      2:       return DIST_W'($urandom_range(0, 255));
      3:       return DIST_W'($urandom_range(0, 1 << 20));
      4:       return {DIST_W{1'b1}};
      5:       return 34'd12884115075;
      6:       return DIST_W'({$urandom, $urandom});
      default: return MAX_DIST_RESET;
    endcase
  endfunction

  // Offer one word, holding it until accepted. Entered and left at a falling edge;
  // valid stays high on return so back-to-back words need no extra assignment.
  task automatic send_word(input in_word_t w);
    while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
    if (w.req_type == REQ_LOAD) begin
      slot_loaded[w.entry_index] = 1'b1;
      while (loaded_prefix < NPS_MAX_POINTS && slot_loaded[loaded_prefix]) loaded_prefix++;
    end
  endtask

  // Wait for the block to go quiet, then write both registers on adjacent edges.
  task automatic apply_settings(input logic [COUNT_W-1:0] count,
                                input logic [DIST_W-1:0] limit);
    in_valid <= 1'b0;
    while (sb.pending_nearest.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_POINT_COUNT;
    cfg_wdata <= CFG_DATA_W'(count);
    @(negedge clk);
    cfg_index <= REG_MAX_DIST_SQ;
    cfg_wdata <= CFG_DATA_W'(limit);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(REG_POINT_COUNT, CFG_DATA_W'(count));
    sb.set_reg(REG_MAX_DIST_SQ, CFG_DATA_W'(limit));
  endtask

  // Query either close to a point inside the scan window or anywhere at all.
  task automatic send_query(input logic [COUNT_W-1:0] count);
    int k, span;
    if (count != 0 && $urandom_range(0, 1) == 1) begin
      k    = $urandom_range(0, (count > NPS_MAX_POINTS ? NPS_MAX_POINTS : count) - 1);
      span = ($urandom_range(0, 4) == 0) ? 0 : 8;
      send_word(make_word(REQ_QUERY, IDX_W'($urandom), nudge(sb.pt_x[k], span),
                          nudge(sb.pt_y[k], span), nudge(sb.pt_z[k], span)));
    end else begin
      send_word(make_word(REQ_QUERY, IDX_W'($urandom), rand_coord(), rand_coord(),
                          rand_coord()));
    end
  endtask

  // One setting of the registers followed by a mix of loads and queries.
  task automatic run_round(input int n_items);
    logic [COUNT_W-1:0] count;
    int                 cap, sel, slot, src;
    cap = (loaded_prefix < 48) ? loaded_prefix : 48;
    if ($urandom_range(0, 9) == 0) count = COUNT_W'(loaded_prefix);
    else count = COUNT_W'($urandom_range(0, cap));
    apply_settings(count, random_limit());
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 40) begin
        // grow the prefix, overwrite inside it, or scatter anywhere
        sel = $urandom_range(0, 99);
        if (sel < 50 && loaded_prefix < NPS_MAX_POINTS) slot = loaded_prefix;
        else if (sel < 80 && loaded_prefix > 0) slot = $urandom_range(0, loaded_prefix - 1);
        else slot = $urandom_range(0, NPS_MAX_POINTS - 1);
        if ($urandom_range(0, 6) == 0 && loaded_prefix > 0) begin
          // duplicate an existing point so equal distances occur
          src = $urandom_range(0, loaded_prefix - 1);
          send_word(make_word(REQ_LOAD, IDX_W'(slot), sb.pt_x[src], sb.pt_y[src],
                              sb.pt_z[src]));
        end else begin
          send_word(make_word(REQ_LOAD, IDX_W'(slot), rand_coord(), rand_coord(),
                              rand_coord()));
        end
      end else begin
        send_query(count);
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty table after reset, extremes, ties, threshold boundaries.
    send_word(make_word(REQ_QUERY, 10'h3FF, 16'sd0, 16'sd0, 16'sd0));
    send_word(make_word(REQ_QUERY, 10'h000, 16'sh8000, 16'sh7FFF, 16'shFFFF));
    send_word(make_word(REQ_LOAD, 10'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
    send_word(make_word(REQ_LOAD, 10'd1, 16'sh8000, 16'sh8000, 16'sh8000));
    send_word(make_word(REQ_LOAD, 10'd2, 16'sd0, 16'sd0, 16'sd0));
    send_word(make_word(REQ_LOAD, 10'd3, 16'sd0, 16'sd0, 16'sd0));
    send_word(make_word(REQ_LOAD, 10'd4, 16'sh5555, 16'shAAAA, 16'sh5555));
    send_word(make_word(REQ_LOAD, 10'd1023, 16'shAAAA, 16'sh5555, 16'shAAAA));
    send_word(make_word(REQ_LOAD, 10'd512, 16'sd1, 16'shFFFF, 16'sd255));
    apply_settings(11'd5, MAX_DIST_RESET);
    send_word(make_word(REQ_QUERY, 10'd0, 16'sd0, 16'sd0, 16'sd0));    // slots 2 and 3 tie
    send_word(make_word(REQ_QUERY, 10'd7, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF)); // hit on slot 0
    send_word(make_word(REQ_QUERY, 10'd0, 16'sd16000, 16'sd0, 16'sd0)); // equal to threshold
    send_word(make_word(REQ_QUERY, 10'd0, 16'sd15999, 16'sd0, 16'sd0)); // just inside
    // largest possible distance against the largest threshold and one just below it
    apply_settings(11'd1, {DIST_W{1'b1}});
    send_word(make_word(REQ_QUERY, 10'd0, 16'sh8000, 16'sh8000, 16'sh8000));
    apply_settings(11'd1, 34'd12884115075);
    send_word(make_word(REQ_QUERY, 10'd0, 16'sh8000, 16'sh8000, 16'sh8000));
    // zero threshold can never be beaten; one lets a zero distance through
    apply_settings(11'd5, '0);
    send_word(make_word(REQ_QUERY, 10'd0, 16'sd0, 16'sd0, 16'sd0));
    apply_settings(11'd5, DIST_W'(1));
    send_word(make_word(REQ_QUERY, 10'd0, 16'sd0, 16'sd0, 16'sd0));

    // Random phases: no idling, sender gaps, receiver stalls, then both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 56;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 56;
        end
        default: begin
          gap_pct   = 31;
          stall_pct = 31;
        end
      endcase
      if (ph == 0) begin
        // short queries against a held output: the block must stall its input
        apply_settings(11'd3, MAX_DIST_RESET);
        hold_req = 1'b1;
        repeat (20) send_query(11'd3);
      end
      repeat (4) run_round(34);
    end

    // Scan the whole loaded prefix under the reset threshold and the largest threshold.
    gap_pct   = 31;
    stall_pct = 31;
    apply_settings(COUNT_W'(loaded_prefix), MAX_DIST_RESET);
    repeat (2) send_query(COUNT_W'(loaded_prefix));
    apply_settings(COUNT_W'(loaded_prefix), {DIST_W{1'b1}});
    repeat (2) send_query(COUNT_W'(loaded_prefix));

    in_valid <= 1'b0;
    while (sb.pending_nearest.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_nearest.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
